[src/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define OCCU_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("occu assertion failed");

// property checked at every edge, reset included
`define OCCU_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("occu assertion failed");

`endif

[src/occu_pkg.sv]
// shared types and constants for the ones' complement checksum block
`timescale 1ns / 1ps
`default_nettype none

package occu_pkg;

    localparam logic [15:0] WORD_MASK = 16'hFFFF;
    localparam logic [15:0] BYTE_MASK = 16'h00FF;

    // command codes of the input word
    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ADD     = 2'd1,
        CMD_REPLACE = 2'd2
    } t_cmd;

    // classified operation passed from front to back
    typedef struct packed {
        logic        is_load;
        logic [31:0] value;
        logic        last;
    } t_op;

endpackage

`default_nettype wire

[src/occu_front.sv]
// front end: masks and classifies an input word into a load or an addend
`timescale 1ns / 1ps
`default_nettype none

module occu_front (
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_data_word,
    input  wire logic [15:0] i_old_word,
    input  wire logic        i_odd_byte,
    input  wire logic [31:0] i_load_value,
    input  wire logic        i_last,
    input  wire logic        i_final_mode,
    output occu_pkg::t_op    o_op
);
    import occu_pkg::*;

    logic [15:0] w_dw;
    logic [15:0] w_ow;
    logic [16:0] w_repl;

    // odd trailing byte keeps only the low byte
    assign w_dw = i_odd_byte ? (i_data_word & BYTE_MASK) : i_data_word;
    assign w_ow = i_odd_byte ? (i_old_word & BYTE_MASK) : i_old_word;

    // replace addend: complement of old word plus new word
    assign w_repl = {1'b0, WORD_MASK & ~w_ow} + {1'b0, w_dw};

    // classify the command
    always_comb begin
        o_op.last    = i_last;
        o_op.is_load = 1'b0;
        o_op.value   = 32'd0;
        unique case (t_cmd'(i_command))
            CMD_LOAD: begin
                o_op.is_load = 1'b1;
                o_op.value   = i_final_mode ? {16'd0, WORD_MASK & ~i_load_value[15:0]}
                                            : i_load_value;
            end
            CMD_ADD: begin
                o_op.value = {16'd0, w_dw};
            end
            CMD_REPLACE: begin
                o_op.value = {15'd0, w_repl};
            end
            default: begin
                o_op.value = 32'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/occu_queue.sv]
// two-entry queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module occu_queue (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  occu_pkg::t_op i_op,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_nonempty,
    output occu_pkg::t_op o_op
);
    import occu_pkg::*;

    t_op        r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       n_wptr;
    logic       n_rptr;
    logic [1:0] n_count;

    assign o_full     = (r_count == 2'd2);
    assign o_nonempty = (r_count != 2'd0);
    assign o_op       = r_mem[r_rptr];

    // pointer and count update
    always_comb begin
        n_wptr  = i_push ? ~r_wptr : r_wptr;
        n_rptr  = i_pop ? ~r_rptr : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

endmodule

`default_nettype wire

[src/occu_back.sv]
// back end: running sum, fold on last word in final mode, output register
`timescale 1ns / 1ps
`default_nettype none

module occu_back (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_final_mode,
    input  wire logic        i_q_nonempty,
    input  occu_pkg::t_op    i_q_op,
    output logic             o_q_pop,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_checksum_value
);
    import occu_pkg::*;

    logic [31:0] r_sum;
    logic [31:0] n_sum;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [31:0] r_out_data;
    logic [31:0] n_out_data;
    logic [31:0] w_sum;
    logic [16:0] w_fold1;
    logic [16:0] w_fold2;
    logic [15:0] w_fold;

    // a word without last never needs the output register
    assign o_q_pop = i_q_nonempty && (!i_q_op.last || !r_out_valid || i_ready);

    // accumulate and fold twice
    assign w_sum   = i_q_op.is_load ? i_q_op.value : r_sum + i_q_op.value;
    assign w_fold1 = {1'b0, w_sum[31:16]} + {1'b0, w_sum[15:0]};
    assign w_fold2 = {16'd0, w_fold1[16]} + {1'b0, w_fold1[15:0]};
    assign w_fold  = w_fold2[15:0];

    // next sum and output
    always_comb begin
        n_sum       = r_sum;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;
        if (o_q_pop) begin
            n_sum = (i_q_op.last && i_final_mode) ? {16'd0, w_fold} : w_sum;
            if (i_q_op.last) begin
                n_out_valid = 1'b1;
                n_out_data  = i_final_mode ? {16'd0, WORD_MASK & ~w_fold} : w_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= 32'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_valid          = r_out_valid;
    assign o_checksum_value = r_out_data;

endmodule

`default_nettype wire

[src/ones_complement_checksum_update.sv]
// top level of the streaming ones' complement checksum with incremental update
//
//   channel   direction  handshake          payload
//   input     in         i_valid / o_ready  i_command .. i_last
//   result    out        o_valid / i_ready  o_checksum_value
//   config    in         i_cfg_we           i_cfg_wdata (final_mode)
//
// one word per cycle while o_ready is high; a result passes the queue, then the output register
// the back end's combinational add-and-fold of the running sum sets the rate
// a two-entry queue lets input words keep flowing while a result waits
// synchronous active-low reset: sum zero, final_mode one, queue and output empty
`timescale 1ns / 1ps
`default_nettype none

module ones_complement_checksum_update (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_data_word,
    input  wire logic [15:0] i_old_word,
    input  wire logic        i_odd_byte,
    input  wire logic [31:0] i_load_value,
    input  wire logic        i_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_checksum_value
);
    import occu_pkg::*;

    logic r_final_mode;
    t_op  w_front_op;
    t_op  w_q_op;
    logic w_q_full;
    logic w_q_nonempty;
    logic w_q_pop;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_final_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_final_mode <= i_cfg_wdata;
        end
    end

    assign o_ready = !w_q_full;

    occu_front u_front (
        .i_command    (i_command),
        .i_data_word  (i_data_word),
        .i_old_word   (i_old_word),
        .i_odd_byte   (i_odd_byte),
        .i_load_value (i_load_value),
        .i_last       (i_last),
        .i_final_mode (r_final_mode),
        .o_op         (w_front_op)
    );

    occu_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_valid && !w_q_full),
        .i_op       (w_front_op),
        .o_full     (w_q_full),
        .i_pop      (w_q_pop),
        .o_nonempty (w_q_nonempty),
        .o_op       (w_q_op)
    );

    occu_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_final_mode     (r_final_mode),
        .i_q_nonempty     (w_q_nonempty),
        .i_q_op           (w_q_op),
        .o_q_pop          (w_q_pop),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_checksum_value (o_checksum_value)
    );

endmodule

`default_nettype wire

[src/occu_checker.sv]
// port-level assertions for the checksum block and their bind
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module occu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_checksum_value
);

    // reset empties the output register and the queue
    `OCCU_ASSERT_ALWAYS(a_rst_no_result, !i_rst_n |=> !o_valid)
    `OCCU_ASSERT_ALWAYS(a_rst_ready, !i_rst_n |=> o_ready)

    // the queue only fills up behind a stalled result
    `OCCU_ASSERT(a_full_means_stalled, !o_ready |-> o_valid)

    // a result waits until taken, with its value unchanged
    `OCCU_ASSERT(a_result_holds, o_valid && !i_ready |=> o_valid && $stable(o_checksum_value))

endmodule

bind ones_complement_checksum_update occu_checker u_occu_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_checksum_value (o_checksum_value)
);

`default_nettype wire

[sim/ones_complement_checksum_update_tb.sv]
// self-checking testbench for the streaming ones' complement checksum block
`timescale 1ns / 1ps
`default_nettype none

module ones_complement_checksum_update_tb;
    import occu_pkg::*;

    // command code with no operation behind it; sum is left alone
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // one input word as the testbench sees it
    typedef struct {
        logic [1:0]  command;
        logic [15:0] data_word;
        logic [15:0] old_word;
        logic        odd_byte;
        logic [31:0] load_value;
        logic        last;
    } t_csum_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_command = CMD_LOAD;
    logic [15:0] i_data_word = '0;
    logic [15:0] i_old_word = '0;
    logic        i_odd_byte = 1'b0;
    logic [31:0] i_load_value = '0;
    logic        i_last = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_checksum_value;

    // predicted state of the block
    logic [31:0] model_sum = '0;
    logic        model_final = 1'b1;

    logic [31:0] expected_sums [$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          mismatches = 0;
    int          words_sent = 0;
    int          sums_checked = 0;
    int          cmd_count [4] = '{0, 0, 0, 0};
    int          raw_sums = 0;
    int          folded_sums = 0;
    logic [1:0]  cmd_codes [4] = '{CMD_LOAD, CMD_ADD, CMD_REPLACE, CMD_UNUSED};

    ones_complement_checksum_update u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_data_word      (i_data_word),
        .i_old_word       (i_old_word),
        .i_odd_byte       (i_odd_byte),
        .i_load_value     (i_load_value),
        .i_last           (i_last),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_checksum_value (o_checksum_value)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // apply one word to the running sum; returns 1 with the checksum when one is emitted
    function automatic bit update_running_sum(input t_csum_word w, output logic [31:0] chk);
        logic [15:0] dw;
        logic [15:0] ow;
        logic [31:0] s;
        dw = w.data_word;
        ow = w.old_word;
        chk = '0;
        // trailing odd byte: upper byte counts as zero, also before the complement
        if (w.odd_byte) begin
            dw = dw & BYTE_MASK;
            ow = ow & BYTE_MASK;
        end
        case (w.command)
            CMD_LOAD: begin
                // final mode loads a stored checksum, so undo its complement
                model_sum = model_final ? {16'h0, ~w.load_value[15:0]} : w.load_value;
            end
            CMD_ADD: begin
                model_sum = model_sum + {16'h0, dw};
            end
            CMD_REPLACE: begin
                model_sum = model_sum + {16'h0, ~ow} + {16'h0, dw};
            end
            default: ;
        endcase
        if (!w.last) return 1'b0;
        // final mode: fold carries twice, keep the folded sum, emit its complement
        if (model_final) begin
            s = {16'h0, model_sum[31:16]} + {16'h0, model_sum[15:0]};
            s = {16'h0, s[31:16]} + {16'h0, s[15:0]};
            model_sum = {16'h0, s[15:0]};
            chk = {16'h0, ~s[15:0]};
        end else begin
            chk = model_sum;
        end
        return 1'b1;
    endfunction

    function automatic t_csum_word make_word(input logic [1:0] command, input logic [15:0] data,
                                             input logic [15:0] old, input logic odd,
                                             input logic [31:0] load, input logic last);
        t_csum_word w;
        w.command = command;
        w.data_word = data;
        w.old_word = old;
        w.odd_byte = odd;
        w.load_value = load;
        w.last = last;
        return w;
    endfunction

    function automatic t_csum_word random_word(input logic [1:0] command, input logic last);
        return make_word(command, 16'($urandom), 16'($urandom), ($urandom_range(7) == 0),
                         $urandom, last);
    endfunction

    // drive one word, hold it until taken, then predict its result
    task automatic send_word(input t_csum_word w);
        int gap;
        logic [31:0] chk;
        gap = 0;
        while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= w.command;
        i_data_word <= w.data_word;
        i_old_word <= w.old_word;
        i_odd_byte <= w.odd_byte;
        i_load_value <= w.load_value;
        i_last <= w.last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (update_running_sum(w, chk)) begin
            expected_sums.push_back(chk);
        end
        words_sent++;
        cmd_count[w.command]++;
    endtask

    // change final_mode once the block has gone quiet
    task automatic write_final_mode(input logic mode);
        i_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        // words without last may still be in flight
        repeat (4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= mode;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        model_final = mode;
    endtask

    // compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_sums.size() == 0) begin
                $display("%0t: unexpected checksum, actual %h", $time, o_checksum_value);
                mismatches++;
            end else begin
                if (o_checksum_value !== expected_sums[0]) begin
                    $display("%0t: checksum mismatch, expected %h actual %h",
                             $time, expected_sums[0], o_checksum_value);
                    mismatches++;
                end
                void'(expected_sums.pop_front());
                sums_checked++;
                if (model_final) folded_sums++;
                else raw_sums++;
            end
        end
    end

    // final mode: extremes, carries, odd byte, replace, unused command, folded continuation
    task automatic test_final_directed();
        write_final_mode(1'b1);
        send_word(make_word(CMD_ADD, 16'hFFFF, 16'h0000, 1'b0, 32'h0, 1'b1));
        send_word(make_word(CMD_LOAD, 16'h0000, 16'h0000, 1'b0, 32'hFFFF_FFFF, 1'b1));
        send_word(make_word(CMD_LOAD, 16'hFFFF, 16'hFFFF, 1'b0, 32'h0000_0000, 1'b0));
        send_word(make_word(CMD_ADD, 16'hFFFF, 16'h0000, 1'b0, 32'h0, 1'b0));
        send_word(make_word(CMD_ADD, 16'hFFFF, 16'h0000, 1'b0, 32'h0, 1'b0));
        send_word(make_word(CMD_REPLACE, 16'hFFFF, 16'h0000, 1'b0, 32'h0, 1'b0));
        send_word(make_word(CMD_REPLACE, 16'h0000, 16'hFFFF, 1'b0, 32'h0, 1'b1));
        send_word(make_word(CMD_ADD, 16'hABCD, 16'h5555, 1'b1, 32'h0, 1'b0));
        send_word(make_word(CMD_REPLACE, 16'h34AB, 16'h12FF, 1'b1, 32'h0, 1'b0));
        send_word(make_word(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 1'b1));
        send_word(make_word(CMD_LOAD, 16'h0000, 16'h0000, 1'b1, 32'h1234_5678, 1'b1));
    endtask

    // raw mode: 32-bit wrap, unused command, emit leaves the sum alone
    task automatic test_raw_directed();
        write_final_mode(1'b0);
        send_word(make_word(CMD_LOAD, 16'h0000, 16'h0000, 1'b0, 32'hFFFF_FFF0, 1'b0));
        send_word(make_word(CMD_ADD, 16'hFFFF, 16'h0000, 1'b0, 32'h0, 1'b0));
        send_word(make_word(CMD_REPLACE, 16'hFFFF, 16'h0000, 1'b0, 32'h0, 1'b1));
        send_word(make_word(CMD_UNUSED, 16'h1234, 16'h5678, 1'b0, 32'hDEAD_BEEF, 1'b1));
        send_word(make_word(CMD_LOAD, 16'h0000, 16'h0000, 1'b0, 32'h0000_0000, 1'b1));
        send_word(make_word(CMD_ADD, 16'h0000, 16'h0000, 1'b1, 32'h0, 1'b1));
        send_word(make_word(CMD_LOAD, 16'h0000, 16'h0000, 1'b0, 32'h8000_0001, 1'b0));
        send_word(make_word(CMD_REPLACE, 16'hFFFF, 16'hFFFF, 1'b1, 32'h0, 1'b1));
    endtask

    // packets of random content in one mode, with some noise words mixed in
    task automatic run_packets(input logic mode, input int n_words);
        int sent;
        int len;
        int pos;
        t_csum_word w;
        logic [1:0] c;
        logic lst;
        write_final_mode(mode);
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(9) == 0) begin
                // noise: any command, last at random
                send_word(random_word(cmd_codes[$urandom_range(3)], 1'($urandom_range(1))));
                sent++;
            end else begin
                len = $urandom_range(1, 12);
                for (pos = 0; pos < len && sent < n_words; pos++) begin
                    lst = (pos == len - 1) || (sent == n_words - 1);
                    // most packets start with a load, some continue from the last sum
                    if (pos == 0 && $urandom_range(4) != 0) c = CMD_LOAD;
                    else if ($urandom_range(9) < 7) c = CMD_ADD;
                    else c = CMD_REPLACE;
                    w = random_word(c, lst);
                    w.odd_byte = lst && ($urandom_range(3) == 0);
                    send_word(w);
                    sent++;
                end
            end
        end
    endtask

    // random packets in both modes under one idle pattern
    task automatic test_random_packets(input int send_pct, input int recv_pct,
                                       input logic first_mode);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        run_packets(first_mode, 175);
        run_packets(!first_mode, 175);
    endtask

    // test sequence
    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 20;
        recv_idle_pct = 50;
        test_final_directed();
        test_raw_directed();
        test_random_packets(20, 50, 1'b1);
        test_random_packets(50, 20, 1'b0);
        test_random_packets(0, 0, 1'b1);

        // drain outstanding checksums
        i_valid <= 1'b0;
        while (expected_sums.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("run covered %0d words: %0d load, %0d add, %0d replace, %0d unused",
                 words_sent, cmd_count[CMD_LOAD], cmd_count[CMD_ADD],
                 cmd_count[CMD_REPLACE], cmd_count[CMD_UNUSED]);
        $display("checked %0d checksums (%0d folded, %0d raw) with %0d mismatches",
                 sums_checked, folded_sums, raw_sums, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
